// ===== hw/rtl/segmented_stack_set_assert.svh =====
// Assertion macros for the segmented stack set.
// Included by the top level; no other dependencies.
`ifndef SEGMENTED_STACK_SET_ASSERT_SVH
`define SEGMENTED_STACK_SET_ASSERT_SVH
`ifndef SYNTH
`define SSS_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sss: implication check failed");
`define SSS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sss: next-cycle check failed");
`else
`define SSS_ASSERT_IMP(name, clk, rst, ante, cons)
`define SSS_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

// ===== hw/rtl/sss_pkg.sv =====
// Shared types and constants for the segmented stack set.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sss_pkg;

   typedef enum logic [1:0] {
      ACT_PUSH   = 2'd0,
      ACT_POP    = 2'd1,
      ACT_POP_AT = 2'd2,
      ACT_NOP    = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_EMPTY  = 2'd1,
      ST_FULL   = 2'd2,
      ST_BADSEG = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ORD_LAST  = 2'd0,
      ORD_SIU   = 2'd1,
      ORD_IDX   = 2'd2,
      ORD_KNEXT = 2'd3
   } ord_sel_type;

   localparam logic [4:0] CAP_RESET = 5'd10;

   typedef struct packed {
      logic        capture;
      ord_sel_type ord_sel;
      logic        rd_fill;
      logic        push_store;
      logic        push_new;
      logic        pop_dec;
      logic        popat_dec;
      logic        shift_init;
      logic        shift_wr;
      logic        shift_end;
      logic        set_st;
      status_type  st;
      logic        rd_top;
      logic        emit;
   } cmd_type;

   typedef struct packed {
      action_type act;
      logic       idx_bad;
      logic       seg_full;
      logic       segs_max;
      logic       fill_zero;
      logic       fill_keep;
      logic       shift_more;
   } stat_type;

endpackage
`default_nettype wire

// ===== hw/rtl/sss_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module sss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/sss_ctrl.sv =====
// Controller state machine of the segmented stack set.
// Depends on sss_pkg; drives the datapath through cmd_type.
`timescale 1ns / 1ps
`default_nettype none
module sss_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire sss_pkg::stat_type stat,
   output logic                   busy,
   output logic                   rsp_valid,
   output sss_pkg::cmd_type       cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_ORD,
      S_CHK,
      S_NEWSEG,
      S_SH_CHK,
      S_SH_WR,
      S_RP_ORD,
      S_RP_FILL,
      S_RP_TOP,
      S_RP_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.ord_sel  = sss_pkg::ORD_LAST;
      cmd.st       = sss_pkg::ST_OK;
      rsp_valid_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.act)
               sss_pkg::ACT_PUSH, sss_pkg::ACT_POP: begin
                  state_in = S_ORD;
               end
               sss_pkg::ACT_POP_AT: begin
                  if (stat.idx_bad) begin
                     cmd.set_st = 1'b1;
                     cmd.st     = sss_pkg::ST_BADSEG;
                     state_in   = S_RP_ORD;
                  end else begin
                     cmd.ord_sel = sss_pkg::ORD_IDX;
                     state_in    = S_ORD;
                  end
               end
               default: state_in = S_RP_ORD;
            endcase
         end
         S_ORD: begin
            cmd.rd_fill = 1'b1;
            state_in    = S_CHK;
         end
         S_CHK: begin
            state_in = S_RP_ORD;
            case (stat.act)
               sss_pkg::ACT_PUSH: begin
                  if (stat.seg_full) begin
                     if (stat.segs_max) begin
                        cmd.set_st = 1'b1;
                        cmd.st     = sss_pkg::ST_FULL;
                     end else begin
                        cmd.ord_sel = sss_pkg::ORD_SIU;
                        state_in    = S_NEWSEG;
                     end
                  end else begin
                     cmd.push_store = 1'b1;
                  end
               end
               sss_pkg::ACT_POP: begin
                  if (stat.fill_zero) begin
                     cmd.set_st = 1'b1;
                     cmd.st     = sss_pkg::ST_EMPTY;
                  end else begin
                     cmd.pop_dec = 1'b1;
                  end
               end
               sss_pkg::ACT_POP_AT: begin
                  if (stat.fill_zero) begin
                     cmd.set_st = 1'b1;
                     cmd.st     = sss_pkg::ST_BADSEG;
                  end else if (stat.fill_keep) begin
                     cmd.popat_dec = 1'b1;
                  end else begin
                     cmd.shift_init = 1'b1;
                     state_in       = S_SH_CHK;
                  end
               end
               default: state_in = S_RP_ORD;
            endcase
         end
         S_NEWSEG: begin
            cmd.push_new = 1'b1;
            state_in     = S_RP_ORD;
         end
         S_SH_CHK: begin
            if (stat.shift_more) begin
               cmd.ord_sel = sss_pkg::ORD_KNEXT;
               state_in    = S_SH_WR;
            end else begin
               cmd.shift_end = 1'b1;
               state_in      = S_RP_ORD;
            end
         end
         S_SH_WR: begin
            cmd.shift_wr = 1'b1;
            state_in     = S_SH_CHK;
         end
         S_RP_ORD: begin
            state_in = S_RP_FILL;
         end
         S_RP_FILL: begin
            cmd.rd_fill = 1'b1;
            state_in    = S_RP_TOP;
         end
         S_RP_TOP: begin
            cmd.rd_top = 1'b1;
            state_in   = S_RP_EMIT;
         end
         S_RP_EMIT: begin
            cmd.emit     = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/sss_dp.sv =====
// Datapath of the segmented stack set: counters, order/fill/element RAMs.
// Depends on sss_pkg and sss_ram; commanded by sss_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module sss_dp #(
   parameter int NUM_SEGS  = 16,
   parameter int SEG_DEPTH = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire sss_pkg::cmd_type   cmd,
   output sss_pkg::stat_type       stat,
   input  wire logic [1:0]         req_action,
   input  wire logic signed [31:0] req_value,
   input  wire logic [3:0]         req_seg_index,
   input  wire logic               csr_valid,
   input  wire logic [4:0]         csr_wdata,
   output logic [1:0]              rsp_status,
   output logic                    rsp_top_valid,
   output logic signed [31:0]      rsp_top_value,
   output logic [8:0]              rsp_total_count,
   output logic [4:0]              rsp_segment_count
);

   localparam int SEG_W  = (NUM_SEGS > 1) ? $clog2(NUM_SEGS) : 1;
   localparam int CNT_W  = $clog2(NUM_SEGS + 1);
   localparam int FILL_W = $clog2(SEG_DEPTH + 1);
   localparam int ELEMS  = NUM_SEGS * SEG_DEPTH;
   localparam int EA_W   = (ELEMS > 1) ? $clog2(ELEMS) : 1;
   localparam int TOT_W  = $clog2(ELEMS + 1);

   function automatic logic [EA_W-1:0] elem_addr(input logic [SEG_W-1:0]  p,
                                                 input logic [FILL_W-1:0] f);
      return EA_W'(32'(p) * 32'(SEG_DEPTH) + 32'(f));
   endfunction

   sss_pkg::action_type act_ff;
   sss_pkg::status_type st_ff;
   logic [31:0]         val_ff;
   logic [3:0]          idx_ff;
   logic [CNT_W-1:0]    siu_ff, siu_in;
   logic [TOT_W-1:0]    tot_ff, tot_in;
   logic [4:0]          cap_ff;
   logic [SEG_W-1:0]    p_ff;
   logic [SEG_W-1:0]    k_ff;
   logic [FILL_W-1:0]   f_ff;
   logic [NUM_SEGS-1:0] ord_vld_ff;
   logic [NUM_SEGS-1:0] fill_vld_ff;
   logic                ord_hit_ff;
   logic [SEG_W-1:0]    ord_ra_ff;
   logic                fill_hit_ff;

   logic [1:0]          rsp_status_ff;
   logic                rsp_top_valid_ff;
   logic [31:0]         rsp_top_value_ff;
   logic [8:0]          rsp_total_count_ff;
   logic [4:0]          rsp_segment_count_ff;

   logic                ord_we;
   logic [SEG_W-1:0]    ord_waddr, ord_wdata, ord_raddr, ord_q, ord_data;
   logic                fill_we;
   logic [SEG_W-1:0]    fill_waddr;
   logic [FILL_W-1:0]   fill_wdata, fill_q, fill_data, cap_eff;
   logic                elem_we;
   logic [EA_W-1:0]     elem_waddr, elem_raddr;
   logic [31:0]         elem_q;

   sss_ram #(.WIDTH(SEG_W), .DEPTH(NUM_SEGS)) u_ord_ram (
      .clock (clock),
      .we    (ord_we),
      .waddr (ord_waddr),
      .wdata (ord_wdata),
      .raddr (ord_raddr),
      .rdata (ord_q)
   );

   sss_ram #(.WIDTH(FILL_W), .DEPTH(NUM_SEGS)) u_fill_ram (
      .clock (clock),
      .we    (fill_we),
      .waddr (fill_waddr),
      .wdata (fill_wdata),
      .raddr (ord_data),
      .rdata (fill_q)
   );

   sss_ram #(.WIDTH(32), .DEPTH(ELEMS)) u_elem_ram (
      .clock (clock),
      .we    (elem_we),
      .waddr (elem_waddr),
      .wdata (val_ff),
      .raddr (elem_raddr),
      .rdata (elem_q)
   );

   // unwritten order entries read as identity, unwritten fills as zero
   assign ord_data  = ord_hit_ff ? ord_q : ord_ra_ff;
   assign fill_data = fill_hit_ff ? fill_q : '0;

   always_comb begin
      if (cap_ff == 5'd0) begin
         cap_eff = FILL_W'(1);
      end else if (32'(cap_ff) > 32'(SEG_DEPTH)) begin
         cap_eff = FILL_W'(SEG_DEPTH);
      end else begin
         cap_eff = FILL_W'(cap_ff);
      end
   end

   always_comb begin
      case (cmd.ord_sel)
         sss_pkg::ORD_LAST:  ord_raddr = SEG_W'(siu_ff - CNT_W'(1));
         sss_pkg::ORD_SIU:   ord_raddr = SEG_W'(siu_ff);
         sss_pkg::ORD_IDX:   ord_raddr = SEG_W'(idx_ff);
         sss_pkg::ORD_KNEXT: ord_raddr = k_ff + SEG_W'(1);
         default:            ord_raddr = SEG_W'(siu_ff - CNT_W'(1));
      endcase
   end

   always_comb begin
      ord_we     = cmd.shift_wr | cmd.shift_end;
      ord_waddr  = cmd.shift_end ? SEG_W'(siu_ff - CNT_W'(1)) : k_ff;
      ord_wdata  = cmd.shift_end ? p_ff : ord_data;
      fill_we    = cmd.push_store | cmd.push_new | cmd.pop_dec | cmd.popat_dec |
                   cmd.shift_end;
      fill_waddr = cmd.push_new ? ord_data : p_ff;
      fill_wdata = '0;
      if (cmd.push_store) begin
         fill_wdata = fill_data + FILL_W'(1);
      end else if (cmd.push_new) begin
         fill_wdata = FILL_W'(1);
      end else if (cmd.pop_dec || cmd.popat_dec) begin
         fill_wdata = fill_data - FILL_W'(1);
      end
      elem_we    = cmd.push_store | cmd.push_new;
      elem_waddr = cmd.push_new ? elem_addr(ord_data, '0) : elem_addr(p_ff, fill_data);
      elem_raddr = elem_addr(p_ff, fill_data - FILL_W'(1));
   end

   always_comb begin
      siu_in = siu_ff;
      tot_in = tot_ff;
      if (cmd.push_store || cmd.push_new) begin
         tot_in = tot_ff + TOT_W'(1);
      end
      if (cmd.pop_dec || cmd.popat_dec || cmd.shift_init) begin
         tot_in = tot_ff - TOT_W'(1);
      end
      if (cmd.push_new) begin
         siu_in = siu_ff + CNT_W'(1);
      end
      if (cmd.shift_end ||
          (cmd.pop_dec && fill_data == FILL_W'(1) && siu_ff > CNT_W'(1))) begin
         siu_in = siu_ff - CNT_W'(1);
      end
   end

   always_comb begin
      stat.act        = act_ff;
      stat.idx_bad    = 32'(idx_ff) >= 32'(siu_ff);
      stat.seg_full   = fill_data >= cap_eff;
      stat.segs_max   = 32'(siu_ff) >= 32'(NUM_SEGS);
      stat.fill_zero  = fill_data == '0;
      stat.fill_keep  = (fill_data > FILL_W'(1)) || (siu_ff == CNT_W'(1));
      stat.shift_more = (32'(k_ff) + 32'd1) < 32'(siu_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff      <= sss_pkg::ACT_NOP;
         siu_ff      <= CNT_W'(1);
         tot_ff      <= '0;
         cap_ff      <= sss_pkg::CAP_RESET;
         ord_vld_ff  <= '0;
         fill_vld_ff <= '0;
      end else begin
         siu_ff <= siu_in;
         tot_ff <= tot_in;
         if (cmd.capture) begin
            act_ff <= sss_pkg::action_type'(req_action);
         end
         if (csr_valid) begin
            cap_ff <= csr_wdata;
         end
         if (ord_we) begin
            ord_vld_ff[ord_waddr] <= 1'b1;
         end
         if (fill_we) begin
            fill_vld_ff[fill_waddr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      ord_hit_ff  <= ord_vld_ff[ord_raddr];
      ord_ra_ff   <= ord_raddr;
      fill_hit_ff <= fill_vld_ff[ord_data];
      if (cmd.capture) begin
         val_ff <= req_value;
         idx_ff <= req_seg_index;
         st_ff  <= sss_pkg::ST_OK;
      end
      if (cmd.set_st) begin
         st_ff <= cmd.st;
      end
      if (cmd.rd_fill || cmd.push_new) begin
         p_ff <= ord_data;
      end
      if (cmd.shift_init) begin
         k_ff <= SEG_W'(idx_ff);
      end else if (cmd.shift_wr) begin
         k_ff <= k_ff + SEG_W'(1);
      end
      if (cmd.rd_top) begin
         f_ff <= fill_data;
      end
      if (cmd.emit) begin
         rsp_status_ff        <= st_ff;
         rsp_top_valid_ff     <= tot_ff != '0;
         rsp_top_value_ff     <= (tot_ff != '0 && f_ff != '0) ? elem_q : 32'd0;
         rsp_total_count_ff   <= 9'(tot_ff);
         rsp_segment_count_ff <= 5'(siu_ff);
      end
   end

   assign rsp_status        = rsp_status_ff;
   assign rsp_top_valid     = rsp_top_valid_ff;
   assign rsp_top_value     = signed'(rsp_top_value_ff);
   assign rsp_total_count   = rsp_total_count_ff;
   assign rsp_segment_count = rsp_segment_count_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/segmented_stack_set.sv =====
// Segmented stack set: a stack kept as an ordered list of fixed-size segments.
// Pulse start while busy is low to issue push (action 0), pop (1) or pop-at (2).
// The transfer is taken at that edge; busy stays high until the result is out.
// One result per item, shown for exactly one cycle with rsp_valid high; the
// receiver cannot stall, so the result must be taken in that cycle.
// Steps per item: decode, order read, fill check, then a new-segment write for
// a push that opens a segment or the shift loop for a pop-at that erases one,
// then result reads of order, fill and top, and the emit; action 3 and an
// out-of-range index go from decode straight to the result reads. A new item
// can be taken in the rsp_valid cycle, not while one is still in work. The
// steps follow from the single read port of the order, fill and element RAMs
// (each access one registered read) and the entry-by-entry shift on an erase.
// csr_wdata (capacity) is taken whenever csr_valid is high; write it only
// while idle. Reset: synchronous, active high; one empty segment, capacity 10.
// The element store is not cleared and needs no clearing pass.
// Depends on sss_pkg, sss_ctrl, sss_dp, sss_ram and the assertion header.
`timescale 1ns / 1ps
`default_nettype none
`include "segmented_stack_set_assert.svh"
module segmented_stack_set #(
   parameter int NUM_SEGS  = 16,
   parameter int SEG_DEPTH = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_action,
   input  wire logic signed [31:0] req_value,
   input  wire logic [3:0]         req_seg_index,
   output logic                    rsp_valid,
   output logic [1:0]              rsp_status,
   output logic                    rsp_top_valid,
   output logic signed [31:0]      rsp_top_value,
   output logic [8:0]              rsp_total_count,
   output logic [4:0]              rsp_segment_count,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [4:0]         csr_wdata
);

   sss_pkg::cmd_type  cmd;
   sss_pkg::stat_type stat;

   assign csr_ready = 1'b1;

   sss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   sss_dp #(.NUM_SEGS(NUM_SEGS), .SEG_DEPTH(SEG_DEPTH)) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_action        (req_action),
      .req_value         (req_value),
      .req_seg_index     (req_seg_index),
      .csr_valid         (csr_valid),
      .csr_wdata         (csr_wdata),
      .rsp_status        (rsp_status),
      .rsp_top_valid     (rsp_top_valid),
      .rsp_top_value     (rsp_top_value),
      .rsp_total_count   (rsp_total_count),
      .rsp_segment_count (rsp_segment_count)
   );

   `SSS_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `SSS_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid)
   `SSS_ASSERT_IMP(a_rsp_idle, clock, reset, rsp_valid, !busy)
   `SSS_ASSERT_IMP(a_full_all_segs, clock, reset,
      rsp_valid && rsp_status == sss_pkg::ST_FULL, rsp_segment_count == 5'(NUM_SEGS))

endmodule
`default_nettype wire

// ===== test/sss_checker.sv =====
// Checker for the segmented stack set: watches the command, result and capacity
// channels, predicts each result from its own copy of the segment list and compares.
// Depends on sss_pkg.
`timescale 1ns / 1ps
module sss_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [1:0]         req_action,
   input  logic signed [31:0] req_value,
   input  logic [3:0]         req_seg_index,
   input  logic               rsp_valid,
   input  logic [1:0]         rsp_status,
   input  logic               rsp_top_valid,
   input  logic signed [31:0] rsp_top_value,
   input  logic [8:0]         rsp_total_count,
   input  logic [4:0]         rsp_segment_count,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [4:0]         csr_wdata,
   output int                 fail_count,
   output int                 pending
);

   typedef struct packed {
      sss_pkg::status_type status;
      logic                top_valid;
      logic signed [31:0]  top_value;
      logic [8:0]          total_count;
      logic [4:0]          segment_count;
   } report_type;

   report_type report_q[$];

   logic [3:0]  seg_order [16];
   logic [4:0]  seg_fill  [16];
   logic [31:0] elem_mem  [256];
   logic [4:0]  seg_live;
   logic [8:0]  elem_total;
   logic [4:0]  capacity;

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   task automatic clear_stack();
      int i;
      for (i = 0; i < 16; i++) begin
         seg_order[i] = i[3:0];
         seg_fill[i]  = 5'd0;
      end
      seg_live   = 5'd1;
      elem_total = 9'd0;
      capacity   = sss_pkg::CAP_RESET;
   endtask

   task automatic apply_op(input sss_pkg::action_type act, input logic [31:0] val,
                           input logic [3:0] idx, output report_type rep);
      logic [3:0]          phys;
      logic [4:0]          depth;
      logic [4:0]          slot;
      sss_pkg::status_type st;
      int                  k;
      depth = (capacity == 5'd0) ? 5'd1 : ((capacity > 5'd16) ? 5'd16 : capacity);
      st    = sss_pkg::ST_OK;
      phys  = seg_order[seg_live - 5'd1];
      case (act)
         sss_pkg::ACT_PUSH: begin
            if (seg_fill[phys] >= depth && seg_live >= 5'd16) begin
               st = sss_pkg::ST_FULL;
            end else begin
               if (seg_fill[phys] >= depth) begin
                  phys           = seg_order[seg_live[3:0]];
                  seg_fill[phys] = 5'd0;
                  seg_live       = seg_live + 5'd1;
               end
               elem_mem[{phys, seg_fill[phys][3:0]}] = val;
               seg_fill[phys] = seg_fill[phys] + 5'd1;
               elem_total     = elem_total + 9'd1;
            end
         end
         sss_pkg::ACT_POP: begin
            if (seg_fill[phys] == 5'd0) begin
               st = sss_pkg::ST_EMPTY;
            end else begin
               seg_fill[phys] = seg_fill[phys] - 5'd1;
               elem_total     = elem_total - 9'd1;
               if (seg_fill[phys] == 5'd0 && seg_live > 5'd1) seg_live = seg_live - 5'd1;
            end
         end
         sss_pkg::ACT_POP_AT: begin
            if ({1'b0, idx} >= seg_live) begin
               st = sss_pkg::ST_BADSEG;
            end else begin
               phys = seg_order[idx];
               if (seg_fill[phys] == 5'd0) begin
                  st = sss_pkg::ST_BADSEG;
               end else begin
                  elem_total = elem_total - 9'd1;
                  if (seg_fill[phys] > 5'd1 || seg_live == 5'd1) begin
                     seg_fill[phys] = seg_fill[phys] - 5'd1;
                  end else begin
                     // erase the segment, later ones close up, freed one goes to the tail
                     for (k = idx; k + 1 < seg_live; k++) seg_order[k] = seg_order[k + 1];
                     seg_order[seg_live - 5'd1] = phys;
                     seg_fill[phys]             = 5'd0;
                     seg_live                   = seg_live - 5'd1;
                  end
               end
            end
         end
         default: ;
      endcase
      phys              = seg_order[seg_live - 5'd1];
      slot              = seg_fill[phys] - 5'd1;
      rep.status        = st;
      rep.top_valid     = (elem_total != 9'd0);
      rep.top_value     = (elem_total != 9'd0 && seg_fill[phys] != 5'd0) ?
                          elem_mem[{phys, slot[3:0]}] : 32'd0;
      rep.total_count   = elem_total;
      rep.segment_count = seg_live;
   endtask

   always @(posedge clock) begin
      report_type want;
      report_type got;
      if (reset) begin
         clear_stack();
         report_q.delete();
      end else begin
         if (rsp_valid) begin
            if (report_q.size() == 0) begin
               $error("unexpected result: status %0d total %0d", rsp_status, rsp_total_count);
               fail_count++;
            end else begin
               want = report_q.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  fail_count++;
               end
               if (rsp_top_valid !== want.top_valid) begin
                  $error("top_valid: expected %0d, got %0d", want.top_valid, rsp_top_valid);
                  fail_count++;
               end
               if (rsp_top_value !== want.top_value) begin
                  $error("top_value: expected %0d, got %0d", want.top_value, rsp_top_value);
                  fail_count++;
               end
               if (rsp_total_count !== want.total_count) begin
                  $error("total_count: expected %0d, got %0d", want.total_count,
                         rsp_total_count);
                  fail_count++;
               end
               if (rsp_segment_count !== want.segment_count) begin
                  $error("segment_count: expected %0d, got %0d", want.segment_count,
                         rsp_segment_count);
                  fail_count++;
               end
            end
         end
         if (csr_valid && csr_ready) capacity = csr_wdata;
         if (start && !busy) begin
            apply_op(sss_pkg::action_type'(req_action), req_value, req_seg_index, got);
            report_q = {report_q, got};
         end
      end
      pending = report_q.size();
   end

endmodule

// ===== test/tb_segmented_stack_set.sv =====
// Testbench top for segmented_stack_set: reset, capacity phases, directed and random
// push/pop/pop-at traffic in bursts; verdict from sss_checker. Depends on sss_pkg.
`timescale 1ns / 1ps
module tb_segmented_stack_set;

   localparam int QUIET_LIMIT = 4000;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [1:0]          req_action;
   logic signed [31:0]  req_value;
   logic [3:0]          req_seg_index;
   logic                rsp_valid;
   logic [1:0]          rsp_status;
   logic                rsp_top_valid;
   logic signed [31:0]  rsp_top_value;
   logic [8:0]          rsp_total_count;
   logic [4:0]          rsp_segment_count;
   logic                csr_valid;
   logic                csr_ready;
   logic [4:0]          csr_wdata;
   int                  fail_count;
   int                  pending;
   int                  quiet_cycles;

   int                  ph;
   int                  n;
   int                  roll;
   int                  push_pct;
   int                  burst_left;
   sss_pkg::action_type act;
   logic [31:0]         val;
   logic [3:0]          idx;
   logic [4:0]          cap;

   segmented_stack_set u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_value         (req_value),
      .req_seg_index     (req_seg_index),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_top_valid     (rsp_top_valid),
      .rsp_top_value     (rsp_top_value),
      .rsp_total_count   (rsp_total_count),
      .rsp_segment_count (rsp_segment_count),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_wdata         (csr_wdata)
   );

   sss_checker u_check (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_value         (req_value),
      .req_seg_index     (req_seg_index),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_top_valid     (rsp_top_valid),
      .rsp_top_value     (rsp_top_value),
      .rsp_total_count   (rsp_total_count),
      .rsp_segment_count (rsp_segment_count),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_wdata         (csr_wdata),
      .fail_count        (fail_count),
      .pending           (pending)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   initial quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic issue(input sss_pkg::action_type a, input logic [31:0] v,
                        input logic [3:0] i);
      @(negedge clock);
      start         <= 1'b1;
      req_action    <= a;
      req_value     <= v;
      req_seg_index <= i;
      do @(posedge clock); while (busy);
   endtask

   task automatic rest_cycles(input int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   task automatic quiesce();
      @(negedge clock);
      start <= 1'b0;
      while (pending != 0 || busy) @(negedge clock);
   endtask

   task automatic set_capacity(input logic [4:0] c);
      quiesce();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= c;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      reset         = 1'b1;
      start         = 1'b0;
      req_action    = sss_pkg::ACT_PUSH;
      req_value     = 32'd0;
      req_seg_index = 4'd0;
      csr_valid     = 1'b0;
      csr_wdata     = 5'd0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // reset capacity: empty cases, no-op, value extremes, pop-at in place
      issue(sss_pkg::ACT_POP, $urandom, 4'd0);
      issue(sss_pkg::ACT_POP_AT, $urandom, 4'd15);
      issue(sss_pkg::ACT_NOP, $urandom, 4'd0);
      issue(sss_pkg::ACT_PUSH, 32'h7fff_ffff, 4'd0);
      issue(sss_pkg::ACT_PUSH, 32'h8000_0000, 4'd15);
      issue(sss_pkg::ACT_POP_AT, 32'd0, 4'd0);

      // capacity zero acts as one: fill every segment, refuse, erase a middle one
      set_capacity(5'd0);
      for (n = 0; n < 16; n++) issue(sss_pkg::ACT_PUSH, $urandom, 4'(n));
      issue(sss_pkg::ACT_PUSH, $urandom, 4'd0);
      issue(sss_pkg::ACT_POP_AT, $urandom, 4'd5);
      issue(sss_pkg::ACT_POP_AT, $urandom, 4'd15);
      issue(sss_pkg::ACT_POP, 32'hffff_ffff, 4'd0);

      burst_left = $urandom_range(1, 16);
      for (ph = 0; ph < 8; ph++) begin
         case (ph)
            0:       cap = 5'd1;
            1:       cap = 5'd16;
            2:       cap = 5'd31;
            3:       cap = 5'd2;
            4:       cap = 5'd10;
            default: cap = 5'($urandom_range(0, 31));
         endcase
         set_capacity(cap);
         push_pct = (ph % 3 == 2) ? 25 : $urandom_range(50, 85);
         for (n = 0; n < 50; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < push_pct) act = sss_pkg::ACT_PUSH;
            else if (roll < push_pct + (100 - push_pct) / 2) act = sss_pkg::ACT_POP;
            else if (roll < 97) act = sss_pkg::ACT_POP_AT;
            else act = sss_pkg::ACT_NOP;
            if ($urandom_range(0, 9) == 0) begin
               case ($urandom_range(0, 3))
                  0:       val = 32'h7fff_ffff;
                  1:       val = 32'h8000_0000;
                  2:       val = 32'd0;
                  default: val = 32'hffff_ffff;
               endcase
            end else begin
               val = $urandom;
            end
            idx = $urandom_range(0, 1) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
            issue(act, val, idx);
            burst_left--;
            if (burst_left == 0) begin
               rest_cycles(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40));
               burst_left = $urandom_range(1, 16);
            end
         end
      end

      quiesce();
      repeat (60) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
